// ===== hw/rtl/hfr_pkg.sv =====
// shared constants and types of the host frame receiver
`default_nettype none

package hfr_pkg;

  localparam logic [7:0]  PREAMBLE_BYTE     = 8'hA5;
  localparam logic [15:0] LENGTH_LIMIT_INIT = 16'd1020;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_HDR_SUM_BAD = 3'd1;
  localparam logic [2:0] STATUS_TOO_LONG    = 3'd2;
  localparam logic [2:0] STATUS_PLD_SUM_BAD = 3'd3;
  localparam logic [2:0] STATUS_PRE_BAD     = 3'd4;
  localparam logic [2:0] STATUS_TIMEOUT     = 3'd5;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam int OUT_DATA_W = 64;

  // one result item as produced by the frame parser
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [7:0]  payload_byte;
    logic [7:0]  proto_code;
    logic [7:0]  layer_code;
    logic [7:0]  command_id;
    logic [15:0] payload_length;
    logic [7:0]  port_byte;
    logic [2:0]  status;
  } hfr_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/host_frame_receiver.sv =====
// top level of the host frame receiver: handshakes, limit register, output register
//
// Takes one received byte (or a timeout mark) per transfer and can take one in every
// clock cycle. Each byte is parsed in the cycle it is taken; a payload byte or a frame
// end result then sits in the output register and is offered on the master side from
// the next cycle on. The slave side stalls only while that register holds a result
// that is not being taken in the same cycle. A frame end result has tlast set and
// carries the header fields and a status; preamble, header and checksum bytes give no
// transfer of their own. The length limit is written over the cfg port, which is
// always ready, and should only be written while no frame is being received.
`default_nettype none

module host_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] cmd

  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [hfr_pkg::OUT_DATA_W-1:0] m_tdata,
  // [7:0] payload_byte, [15:8] proto_code, [23:16] layer_code, [31:24] command_id,
  // [47:32] payload_length, [55:48] port_byte, [58:56] status, [63:59] zero
  output logic             m_tlast,   // kind: frame end result

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data   // length_limit
);

  logic                 s_xfer;
  logic [15:0]          length_limit;
  hfr_pkg::hfr_result_t res;

  assign s_tready  = !m_tvalid || m_tready;
  assign s_xfer    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  hfr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (s_xfer),
    .cmd          (s_tuser),
    .rx_byte      (s_tdata),
    .length_limit (length_limit),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= hfr_pkg::LENGTH_LIMIT_INIT;
    end else if (cfg_valid && cfg_ready) begin
      length_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= res.valid || (m_tvalid && !m_tready);
    end
  end

  // payload side of the output register, loaded with each new result
  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tlast <= res.last;
      m_tdata <= {5'd0, res.status, res.port_byte, res.payload_length, res.command_id,
                  res.layer_code, res.proto_code, res.payload_byte};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hfr_parser.sv =====
// frame parser: per-byte state update and result decode
`default_nettype none

module hfr_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic               cmd,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [15:0]        length_limit,
  output hfr_pkg::hfr_result_t    res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE2,
    PH_PRE3,
    PH_HDR,
    PH_HSUM,
    PH_PLD,
    PH_PSUM,
    PH_PORT
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  protocol_reg, protocol_reg_next;
  logic [7:0]  layer_reg, layer_reg_next;
  logic [7:0]  command_reg, command_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [7:0]  header_sum, header_sum_next;
  logic [7:0]  payload_sum, payload_sum_next;
  logic        payload_sum_good, payload_sum_good_next;

  logic [15:0] count_inc;
  logic        end_frame;
  logic [2:0]  end_status;

  assign count_inc = byte_count + 16'd1;

  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    protocol_reg_next     = protocol_reg;
    layer_reg_next        = layer_reg;
    command_reg_next      = command_reg;
    length_reg_next       = length_reg;
    header_sum_next       = header_sum;
    payload_sum_next      = payload_sum;
    payload_sum_good_next = payload_sum_good;
    end_frame             = 1'b0;
    end_status            = hfr_pkg::STATUS_OK;
    res                   = '0;

    if (cmd == hfr_pkg::CMD_TIMEOUT) begin
      if (phase != PH_IDLE) begin
        end_frame  = 1'b1;
        end_status = hfr_pkg::STATUS_TIMEOUT;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (rx_byte == hfr_pkg::PREAMBLE_BYTE) begin
            byte_count_next       = '0;
            protocol_reg_next     = '0;
            layer_reg_next        = '0;
            command_reg_next      = '0;
            length_reg_next       = '0;
            header_sum_next       = '0;
            payload_sum_next      = '0;
            payload_sum_good_next = 1'b0;
            phase_next            = PH_PRE2;
          end
        end
        PH_PRE2: begin
          if (rx_byte != hfr_pkg::PREAMBLE_BYTE) begin
            end_frame  = 1'b1;
            end_status = hfr_pkg::STATUS_PRE_BAD;
          end else begin
            phase_next = PH_PRE3;
          end
        end
        PH_PRE3: begin
          phase_next      = PH_HDR;
          byte_count_next = '0;
        end
        PH_HDR: begin
          header_sum_next = header_sum + rx_byte;
          case (byte_count)
            16'd0:   protocol_reg_next = rx_byte;
            16'd1:   layer_reg_next    = rx_byte;
            16'd2:   command_reg_next  = rx_byte;
            16'd3:   length_reg_next   = {8'd0, rx_byte};
            default: length_reg_next   = length_reg | {rx_byte, 8'd0};
          endcase
          if (byte_count >= 16'd4) begin
            phase_next      = PH_HSUM;
            byte_count_next = '0;
          end else begin
            byte_count_next = count_inc;
          end
        end
        PH_HSUM: begin
          if (~header_sum != rx_byte) begin
            end_frame  = 1'b1;
            end_status = hfr_pkg::STATUS_HDR_SUM_BAD;
          end else if (!(length_reg < length_limit)) begin
            end_frame  = 1'b1;
            end_status = hfr_pkg::STATUS_TOO_LONG;
          end else begin
            byte_count_next  = '0;
            payload_sum_next = '0;
            phase_next       = (length_reg == 16'd0) ? PH_PSUM : PH_PLD;
          end
        end
        PH_PLD: begin
          payload_sum_next = payload_sum + rx_byte;
          byte_count_next  = count_inc;
          if (count_inc >= length_reg) begin
            phase_next = PH_PSUM;
          end
          res.valid        = 1'b1;
          res.payload_byte = rx_byte;
        end
        PH_PSUM: begin
          payload_sum_good_next = (~payload_sum == rx_byte);
          phase_next            = PH_PORT;
        end
        PH_PORT: begin
          end_frame  = 1'b1;
          end_status = payload_sum_good ? hfr_pkg::STATUS_OK : hfr_pkg::STATUS_PLD_SUM_BAD;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (end_frame) begin
      phase_next         = PH_IDLE;
      res.valid          = 1'b1;
      res.last           = 1'b1;
      res.proto_code     = protocol_reg;
      res.layer_code     = layer_reg;
      res.command_id     = command_reg;
      res.payload_length = length_reg;
      res.port_byte      = (end_status == hfr_pkg::STATUS_OK) ? rx_byte : 8'd0;
      res.status         = end_status;
    end

    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      byte_count       <= '0;
      protocol_reg     <= '0;
      layer_reg        <= '0;
      command_reg      <= '0;
      length_reg       <= '0;
      header_sum       <= '0;
      payload_sum      <= '0;
      payload_sum_good <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      protocol_reg     <= protocol_reg_next;
      layer_reg        <= layer_reg_next;
      command_reg      <= command_reg_next;
      length_reg       <= length_reg_next;
      header_sum       <= header_sum_next;
      payload_sum      <= payload_sum_next;
      payload_sum_good <= payload_sum_good_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_host_frame_receiver.sv =====
// self-checking testbench of the host frame receiver with its own frame parser model
module tb_host_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAP_PCT        = 31;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHOWN_FAILS    = 10;

  typedef enum logic [2:0] {
    PH_IDLE, PH_PRE2, PH_PRE3, PH_HDR, PH_HSUM, PH_PLD, PH_PSUM, PH_PORT
  } rx_phase_t;

  typedef enum int {FLAW_NONE, FLAW_PRE, FLAW_HSUM, FLAW_PSUM} flaw_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] b;
  } rx_item_t;

  // laid out as {m_tlast, m_tdata}
  typedef struct packed {
    logic        last;
    logic [4:0]  pad;
    logic [2:0]  status;
    logic [7:0]  port;
    logic [15:0] len;
    logic [7:0]  command;
    logic [7:0]  layer;
    logic [7:0]  proto;
    logic [7:0]  data;
  } deframe_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [hfr_pkg::OUT_DATA_W-1:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  host_frame_receiver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial forever #6 clk = ~clk;

  rx_item_t     rx_backlog[$];
  deframe_out_t frame_outs_due[$];

  bit  in_taken  = 1'b0;
  bit  no_gaps   = 1'b0;
  int  hold_left = 0;
  int  n_queued  = 0;
  int  n_in      = 0;
  int  n_payload = 0;
  int  n_cfg     = 0;
  int  n_fail    = 0;
  int  idle_cycles = 0;
  int  end_count[6];

  // parser model state
  rx_phase_t   rx_phase;
  logic [15:0] len_limit;
  logic [15:0] hdr_idx;
  logic [15:0] pld_count;
  logic [7:0]  f_proto, f_layer, f_cmd;
  logic [15:0] f_len;
  logic [7:0]  hdr_sum, pld_sum;
  logic        pld_ok;

  task automatic clear_frame_regs();
    hdr_idx   = '0;
    pld_count = '0;
    f_proto   = '0;
    f_layer   = '0;
    f_cmd     = '0;
    f_len     = '0;
    hdr_sum   = '0;
    pld_sum   = '0;
    pld_ok    = 1'b0;
  endtask

  task automatic close_frame(input logic [2:0] st, input logic [7:0] port);
    deframe_out_t r;
    r = '0;
    r.last    = 1'b1;
    r.status  = st;
    r.port    = (st == hfr_pkg::STATUS_OK) ? port : 8'h00;
    r.len     = f_len;
    r.command = f_cmd;
    r.layer   = f_layer;
    r.proto   = f_proto;
    frame_outs_due.push_back(r);
    end_count[st]++;
    rx_phase = PH_IDLE;
  endtask

  task automatic parse_rx(input logic cmd, input logic [7:0] b);
    deframe_out_t r;
    if (cmd == hfr_pkg::CMD_TIMEOUT) begin
      if (rx_phase != PH_IDLE) close_frame(hfr_pkg::STATUS_TIMEOUT, 8'h00);
    end else begin
      case (rx_phase)
        PH_IDLE: begin
          if (b == hfr_pkg::PREAMBLE_BYTE) begin
            clear_frame_regs();
            rx_phase = PH_PRE2;
          end
        end
        PH_PRE2: begin
          if (b != hfr_pkg::PREAMBLE_BYTE) close_frame(hfr_pkg::STATUS_PRE_BAD, 8'h00);
          else rx_phase = PH_PRE3;
        end
        PH_PRE3: begin
          rx_phase = PH_HDR;
          hdr_idx  = '0;
        end
        PH_HDR: begin
          hdr_sum = hdr_sum + b;
          case (hdr_idx)
            16'd0:   f_proto = b;
            16'd1:   f_layer = b;
            16'd2:   f_cmd   = b;
            16'd3:   f_len   = {8'h00, b};
            default: f_len   = f_len | {b, 8'h00};
          endcase
          if (hdr_idx >= 16'd4) begin
            rx_phase = PH_HSUM;
            hdr_idx  = '0;
          end else begin
            hdr_idx = hdr_idx + 16'd1;
          end
        end
        PH_HSUM: begin
          if (~hdr_sum != b) close_frame(hfr_pkg::STATUS_HDR_SUM_BAD, 8'h00);
          else if (!(f_len < len_limit)) close_frame(hfr_pkg::STATUS_TOO_LONG, 8'h00);
          else begin
            pld_count = '0;
            pld_sum   = '0;
            if (f_len == 16'd0) rx_phase = PH_PSUM;
            else rx_phase = PH_PLD;
          end
        end
        PH_PLD: begin
          pld_sum   = pld_sum + b;
          pld_count = pld_count + 16'd1;
          if (pld_count >= f_len) rx_phase = PH_PSUM;
          r = '0;
          r.data = b;
          frame_outs_due.push_back(r);
          n_payload++;
        end
        PH_PSUM: begin
          pld_ok   = (~pld_sum == b);
          rx_phase = PH_PORT;
        end
        PH_PORT: close_frame(pld_ok ? hfr_pkg::STATUS_OK : hfr_pkg::STATUS_PLD_SUM_BAD, b);
        default: rx_phase = PH_IDLE;
      endcase
    end
  endtask

  function automatic string show(input deframe_out_t r);
    return $sformatf({"last %0b status %0d port %02h len %04h cmd %02h layer %02h ",
                      "proto %02h byte %02h pad %02h"},
                     r.last, r.status, r.port, r.len, r.command, r.layer, r.proto,
                     r.data, r.pad);
  endfunction

  // input side: transfer detection and prediction
  always @(posedge clk) begin
    if (rst) begin
      rx_phase  = PH_IDLE;
      len_limit = hfr_pkg::LENGTH_LIMIT_INIT;
      clear_frame_regs();
      in_taken  = 1'b0;
    end else begin
      in_taken = s_tvalid && s_tready;
      if (in_taken) begin
        parse_rx(s_tuser, s_tdata);
        n_in++;
      end
    end
  end

  // driver: offers the next pending item once the previous one was taken
  always @(negedge clk) begin
    rx_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (rx_backlog.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
        nxt = rx_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.cmd;
        s_tdata  <= nxt.b;
      end else begin
        s_tvalid <= 1'b0;
        s_tuser  <= 1'($urandom);
        s_tdata  <= 8'($urandom);
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
    end
  end

  // monitor
  always @(posedge clk) begin
    deframe_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata};
      if (frame_outs_due.size() == 0) begin
        n_fail++;
        if (n_fail <= SHOWN_FAILS) $display("unexpected result: %s", show(got));
      end else begin
        want = frame_outs_due.pop_front();
        if (got !== want) begin
          n_fail++;
          if (n_fail <= SHOWN_FAILS) begin
            $display("mismatch, expected: %s", show(want));
            $display("           actual: %s", show(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, frame_outs_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_rx(input logic cmd, input logic [7:0] b);
    rx_backlog.push_back({cmd, b});
    n_queued++;
  endtask

  // cut >= 0 stops the frame after that many bytes and follows it with a timeout
  task automatic queue_frame(input logic [7:0] proto, input logic [7:0] layer,
                             input logic [7:0] command, input logic [15:0] len,
                             input flaw_t flaw, input int cut);
    logic [7:0] fb[$];
    logic [7:0] hs, ps, v;
    int n, i;
    fb.push_back(hfr_pkg::PREAMBLE_BYTE);
    if (flaw == FLAW_PRE) begin
      do v = 8'($urandom); while (v == hfr_pkg::PREAMBLE_BYTE);
      fb.push_back(v);
    end else begin
      fb.push_back(hfr_pkg::PREAMBLE_BYTE);
      fb.push_back(8'($urandom));
      fb.push_back(proto);
      fb.push_back(layer);
      fb.push_back(command);
      fb.push_back(len[7:0]);
      fb.push_back(len[15:8]);
      hs = proto + layer + command + len[7:0] + len[15:8];
      v = ~hs;
      if (flaw == FLAW_HSUM) v = v ^ (8'h01 << $urandom_range(7));
      fb.push_back(v);
      // a rejected length leaves no payload to send
      n = (len < len_limit) ? int'(len) : 0;
      ps = 8'h00;
      for (i = 0; i < n && (cut < 0 || fb.size() < cut); i++) begin
        v = 8'($urandom);
        ps = ps + v;
        fb.push_back(v);
      end
      v = ~ps;
      if (flaw == FLAW_PSUM) v = v ^ (8'h01 << $urandom_range(7));
      fb.push_back(v);
      fb.push_back(8'($urandom));
    end
    if (cut >= 0)
      while (fb.size() > cut) fb.delete(fb.size() - 1);
    for (i = 0; i < fb.size(); i++) push_rx(hfr_pkg::CMD_BYTE, fb[i]);
    if (cut >= 0) push_rx(hfr_pkg::CMD_TIMEOUT, 8'($urandom));
  endtask

  task automatic random_traffic(input int count);
    int stop_at, pick, cut;
    logic [15:0] len;
    flaw_t flaw;
    stop_at = n_queued + count;
    while (n_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_rx(hfr_pkg::CMD_BYTE, 8'($urandom));
      end else if (pick < 11) begin
        push_rx(hfr_pkg::CMD_TIMEOUT, 8'($urandom));
      end else begin
        pick = $urandom_range(39);
        if (pick == 0) len = 16'($urandom);
        else if (pick < 3) len = 16'($urandom_range(100));
        else len = 16'($urandom_range(12));
        pick = $urandom_range(99);
        if (pick < 70) flaw = FLAW_NONE;
        else if (pick < 78) flaw = FLAW_PRE;
        else if (pick < 88) flaw = FLAW_HSUM;
        else flaw = FLAW_PSUM;
        cut = ($urandom_range(99) < 10) ? int'($urandom_range(12, 1)) : -1;
        queue_frame(8'($urandom), 8'($urandom), 8'($urandom), len, flaw, cut);
      end
    end
    // leave the parser idle
    push_rx(hfr_pkg::CMD_TIMEOUT, 8'h00);
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (rx_backlog.size() != 0 || s_tvalid || frame_outs_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    len_limit = v;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, limit at its reset value
    push_rx(hfr_pkg::CMD_TIMEOUT, 8'hFF);
    push_rx(hfr_pkg::CMD_BYTE, 8'h00);
    push_rx(hfr_pkg::CMD_BYTE, 8'hFF);
    push_rx(hfr_pkg::CMD_BYTE, 8'h5A);
    queue_frame(8'hFF, 8'h00, 8'h80, 16'd0, FLAW_NONE, -1);
    queue_frame(8'h00, 8'hFF, 8'h7F, 16'd3, FLAW_NONE, -1);
    queue_frame(8'hA5, 8'hA5, 8'hA5, 16'd1, FLAW_NONE, -1);
    queue_frame(8'h12, 8'h34, 8'h56, 16'd2, FLAW_PRE, -1);
    queue_frame(8'h12, 8'h34, 8'h56, 16'd2, FLAW_HSUM, -1);
    queue_frame(8'h12, 8'h34, 8'h56, 16'd4, FLAW_PSUM, -1);
    queue_frame(8'h01, 8'h02, 8'h03, 16'd1020, FLAW_NONE, -1);
    queue_frame(8'h01, 8'h02, 8'h03, 16'd1019, FLAW_NONE, 12);
    queue_frame(8'h55, 8'hAA, 8'h0F, 16'd5, FLAW_NONE, 5);
    push_rx(hfr_pkg::CMD_TIMEOUT, 8'h00);
    wait_quiet();

    // zero limit rejects everything
    write_limit(16'h0000);
    queue_frame(8'h10, 8'h20, 8'h30, 16'd0, FLAW_NONE, -1);
    queue_frame(8'h10, 8'h20, 8'h30, 16'hFFFF, FLAW_NONE, -1);
    push_rx(hfr_pkg::CMD_TIMEOUT, 8'h00);
    wait_quiet();

    write_limit(16'hFFFF);
    queue_frame(8'hC3, 8'h3C, 8'h99, 16'hFFFF, FLAW_NONE, -1);
    queue_frame(8'hC3, 8'h3C, 8'h99, 16'hFFFE, FLAW_NONE, 14);
    queue_frame(8'h66, 8'h77, 8'h88, 16'd1, FLAW_NONE, -1);
    push_rx(hfr_pkg::CMD_TIMEOUT, 8'h00);
    wait_quiet();

    // random traffic with a small limit and a long receiver hold-off
    write_limit(16'($urandom_range(40, 4)));
    random_traffic(200);
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    wait_quiet();

    // back-to-back stretch without idling
    write_limit(hfr_pkg::LENGTH_LIMIT_INIT);
    no_gaps = 1'b1;
    random_traffic(130);
    wait_quiet();
    no_gaps = 1'b0;

    write_limit(16'd1);
    queue_frame(8'hE1, 8'hE2, 8'hE3, 16'd0, FLAW_NONE, -1);
    queue_frame(8'hE1, 8'hE2, 8'hE3, 16'd1, FLAW_NONE, -1);
    push_rx(hfr_pkg::CMD_TIMEOUT, 8'h00);
    wait_quiet();

    write_limit(16'd300);
    random_traffic(90);
    wait_quiet();

    $display({"frame ends: ok %0d, header sum %0d, too long %0d, payload sum %0d, ",
              "preamble %0d, timeout %0d"},
             end_count[hfr_pkg::STATUS_OK], end_count[hfr_pkg::STATUS_HDR_SUM_BAD],
             end_count[hfr_pkg::STATUS_TOO_LONG], end_count[hfr_pkg::STATUS_PLD_SUM_BAD],
             end_count[hfr_pkg::STATUS_PRE_BAD], end_count[hfr_pkg::STATUS_TIMEOUT]);
    $display("%0d input transfers, %0d payload bytes, %0d limit writes, %0d failures",
             n_in, n_payload, n_cfg, n_fail);
    if (n_fail == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
